>>> sv/pmf_pkg.sv
// ----------------------------------------------------------------------------
// pmf_pkg
// Shared types and constants for the prefixed message framer.
// ----------------------------------------------------------------------------
package pmf_pkg;

    localparam int BUFFER_BYTES_DEF = 32;
    localparam int CMD_DEPTH_DEF    = 2;
    // covers every buffer size up to 64 bytes
    localparam int CNT_MAX_W        = 7;
    localparam int PREFIX_MAX       = 8;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 64;

    localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PREFIX        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PREFIX_LEN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RX_TIMEOUT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SEND_INTERVAL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SEND_EN       = 3'd5;

    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_FAIL    = 2'd2;

    localparam logic [7:0] SPACE_CHAR = 8'h20;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] payload_byte;
        logic       last_of_run;
        logic       led_on;
        logic       send_request;
        logic       overflowed;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  separator_byte;
        logic [63:0] prefix_bytes;
        logic [3:0]  prefix_length;
        logic [31:0] rx_timeout_ticks;
        logic [31:0] send_interval_ticks;
        logic        send_enabled;
    } cfg_t;

    typedef struct packed {
        logic [1:0]           kind;
        logic                 led;
        logic                 snd;
        logic                 ovf;
        logic [3:0]           start;
        logic [CNT_MAX_W-1:0] valid_len;
        logic                 bank;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic bank;
    } run_done_t;

endpackage

>>> sv/pmf_ram.sv
// ----------------------------------------------------------------------------
// pmf_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> sv/pmf_cmd_fifo.sv
// ----------------------------------------------------------------------------
// pmf_cmd_fifo
// Short command queue between the classifying front end and the result engine.
// ----------------------------------------------------------------------------
module pmf_cmd_fifo
    import pmf_pkg::*;
#(
    parameter int DEPTH = CMD_DEPTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("command pushed into full queue");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("command popped from empty queue");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("queue count out of range");
`endif

endmodule

>>> sv/pmf_front.sv
// ----------------------------------------------------------------------------
// pmf_front
// Accepts bytes and ticks, fills the message buffer, checks the prefix,
// keeps link and send timing, and queues one command per result group.
// ----------------------------------------------------------------------------
module pmf_front
    import pmf_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  cfg_t                              cfg,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  in_item_t                          s_data,
    output logic                              push,
    output cmd_t                              push_cmd,
    input  logic                              fifo_full,
    input  run_done_t                         run_done,
    output logic                              ram_wr_en,
    output logic [$clog2(BUFFER_BYTES):0]     ram_wr_addr,
    output logic [7:0]                        ram_wr_data
);

    localparam int IDX_W = $clog2(BUFFER_BYTES);
    localparam int CNT_W = $clog2(BUFFER_BYTES + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;
    logic             bank_reg, bank_next;
    logic [1:0]       busy_reg, busy_next;
    logic [7:0]       prefix_shadow_reg [PREFIX_MAX];
    logic [31:0]      rx_age_reg, rx_age_next;
    logic             rx_started_reg, rx_started_next;
    logic [31:0]      tx_age_reg, tx_age_next;
    logic             tx_started_reg, tx_started_next;
    logic             led_reg, led_next;

    logic             accept;
    logic             is_byte;
    logic             is_sep;
    logic             room;
    logic [CNT_W-1:0] cnt_new;
    logic             ovf_new;
    logic [CNT_W-1:0] valid_len;
    logic [3:0]       eff_len;
    logic [7:0]       pre_eff [PREFIX_MAX];
    logic             match;
    logic [31:0]      rx_inc;
    logic [31:0]      tx_inc;
    logic             led_tick;
    logic             snd;

    assign s_ready = !fifo_full && !busy_reg[bank_reg];
    assign accept  = s_valid && s_ready;
    assign is_byte = !s_data.req_type;
    assign is_sep  = is_byte && (s_data.rx_byte == cfg.separator_byte);
    assign room    = (cnt_reg < CNT_W'(BUFFER_BYTES));
    assign cnt_new = room ? cnt_reg + 1'b1 : cnt_reg;
    assign ovf_new = ovf_reg | !room;
    // without overflow the separator is the last stored byte
    assign valid_len = ovf_new ? CNT_W'(BUFFER_BYTES) : cnt_new - 1'b1;
    assign eff_len   = (cfg.prefix_length > 4'(PREFIX_MAX)) ? 4'(PREFIX_MAX)
                                                            : cfg.prefix_length;

    assign ram_wr_en   = accept && is_byte && room;
    assign ram_wr_addr = {bank_reg, cnt_reg[IDX_W-1:0]};
    assign ram_wr_data = s_data.rx_byte;

    // first bytes of the message as they would look with this byte stored
    always_comb begin
        match = 1'b1;
        for (int i = 0; i < PREFIX_MAX; i++) begin
            if (CNT_W'(i) < cnt_reg) begin
                pre_eff[i] = prefix_shadow_reg[i];
            end else if (room && CNT_W'(i) == cnt_reg) begin
                pre_eff[i] = s_data.rx_byte;
            end else begin
                pre_eff[i] = SPACE_CHAR;
            end
            if (4'(i) < eff_len && pre_eff[i] != cfg.prefix_bytes[8*i +: 8]) begin
                match = 1'b0;
            end
        end
    end

    // saturating age counters
    assign rx_inc   = rx_age_reg + {31'd0, (rx_age_reg != '1)};
    assign tx_inc   = tx_age_reg + {31'd0, (tx_age_reg != '1)};
    assign led_tick = led_reg | (rx_started_reg && (rx_inc > cfg.rx_timeout_ticks));
    assign snd      = cfg.send_enabled && tx_started_reg &&
                      (tx_inc > cfg.send_interval_ticks);

    always_comb begin
        push_cmd           = '0;
        push_cmd.bank      = bank_reg;
        push_cmd.valid_len = CNT_MAX_W'(valid_len);
        push_cmd.start     = eff_len;
        if (s_data.req_type) begin
            push_cmd.kind = KIND_TICK;
            push_cmd.led  = led_tick;
            push_cmd.snd  = snd;
            push_cmd.ovf  = 1'b0;
        end else if (match) begin
            push_cmd.kind = KIND_PAYLOAD;
            push_cmd.led  = 1'b0;
            push_cmd.ovf  = ovf_new;
        end else begin
            push_cmd.kind = KIND_FAIL;
            push_cmd.led  = led_reg;
            push_cmd.ovf  = ovf_new;
        end
    end

    assign push = accept && (s_data.req_type || is_sep);

    always_comb begin
        cnt_next        = cnt_reg;
        ovf_next        = ovf_reg;
        bank_next       = bank_reg;
        busy_next       = busy_reg;
        rx_age_next     = rx_age_reg;
        rx_started_next = rx_started_reg;
        tx_age_next     = tx_age_reg;
        tx_started_next = tx_started_reg;
        led_next        = led_reg;

        if (run_done.done) begin
            busy_next[run_done.bank] = 1'b0;
        end

        if (accept) begin
            if (s_data.req_type) begin
                if (rx_started_reg) begin
                    rx_age_next = rx_inc;
                end
                if (tx_started_reg) begin
                    tx_age_next = snd ? '0 : tx_inc;
                end
                led_next = led_tick;
            end else if (is_sep) begin
                cnt_next = '0;
                ovf_next = 1'b0;
                if (match) begin
                    rx_age_next     = '0;
                    rx_started_next = 1'b1;
                    if (!tx_started_reg) begin
                        tx_started_next = 1'b1;
                        tx_age_next     = '0;
                    end
                    led_next           = 1'b0;
                    busy_next[bank_reg] = 1'b1;
                    bank_next          = !bank_reg;
                end
            end else begin
                cnt_next = cnt_new;
                ovf_next = ovf_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg        <= '0;
            ovf_reg        <= 1'b0;
            bank_reg       <= 1'b0;
            busy_reg       <= '0;
            rx_age_reg     <= '0;
            rx_started_reg <= 1'b0;
            tx_age_reg     <= '0;
            tx_started_reg <= 1'b0;
            led_reg        <= 1'b1;
        end else begin
            cnt_reg        <= cnt_next;
            ovf_reg        <= ovf_next;
            bank_reg       <= bank_next;
            busy_reg       <= busy_next;
            rx_age_reg     <= rx_age_next;
            rx_started_reg <= rx_started_next;
            tx_age_reg     <= tx_age_next;
            tx_started_reg <= tx_started_next;
            led_reg        <= led_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < PREFIX_MAX; i++) begin
            if (ram_wr_en && cnt_reg == CNT_W'(i)) begin
                prefix_shadow_reg[i] <= s_data.rx_byte;
            end
        end
    end

`ifndef ASSERT_OFF
    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        run_done.done |-> busy_reg[run_done.bank])
        else $error("payload run finished on a bank that was not in use");
`endif

endmodule

>>> sv/pmf_back.sv
// ----------------------------------------------------------------------------
// pmf_back
// Result engine: turns queued commands into result transactions, reading
// the payload run out of the message buffer one byte at a time.
// ----------------------------------------------------------------------------
module pmf_back
    import pmf_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          empty,
    output logic                          pop,
    input  cmd_t                          pop_cmd,
    output logic                          ram_rd_en,
    output logic [$clog2(BUFFER_BYTES):0] ram_rd_addr,
    input  logic [7:0]                    ram_rd_data,
    output run_done_t                     run_done,
    output logic                          m_valid,
    input  logic                          m_ready,
    output out_item_t                     m_data
);

    localparam int IDX_W = $clog2(BUFFER_BYTES);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]       state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_data_reg, m_data_next;

    logic out_free;
    logic load;
    logic at_last;

    assign out_free    = !m_valid_reg || m_ready;
    assign at_last     = (pos_reg == IDX_W'(BUFFER_BYTES - 1));
    assign ram_rd_addr = {cmd_reg.bank, pos_reg};
    assign m_valid     = m_valid_reg;
    assign m_data      = m_data_reg;

    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        pos_next      = pos_reg;
        m_data_next   = m_data_reg;
        pop           = 1'b0;
        load          = 1'b0;
        ram_rd_en     = 1'b0;
        run_done      = '0;
        run_done.bank = cmd_reg.bank;

        case (state_reg)
            ST_IDLE: begin
                if (!empty && out_free) begin
                    pop      = 1'b1;
                    cmd_next = pop_cmd;
                    if (pop_cmd.kind == KIND_PAYLOAD) begin
                        pos_next   = IDX_W'(pop_cmd.start);
                        state_next = ST_READ;
                    end else begin
                        load                     = 1'b1;
                        m_data_next.result_kind  = pop_cmd.kind;
                        m_data_next.payload_byte = '0;
                        m_data_next.last_of_run  = 1'b1;
                        m_data_next.led_on       = pop_cmd.led;
                        m_data_next.send_request = pop_cmd.snd;
                        m_data_next.overflowed   = pop_cmd.ovf;
                    end
                end
            end
            ST_READ: begin
                ram_rd_en  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    load                     = 1'b1;
                    m_data_next.result_kind  = KIND_PAYLOAD;
                    // past the message end the buffer reads as spaces
                    m_data_next.payload_byte =
                        (CNT_MAX_W'(pos_reg) < cmd_reg.valid_len) ? ram_rd_data
                                                                  : SPACE_CHAR;
                    m_data_next.last_of_run  = at_last;
                    m_data_next.led_on       = cmd_reg.led;
                    m_data_next.send_request = 1'b0;
                    m_data_next.overflowed   = cmd_reg.ovf;
                    if (at_last) begin
                        run_done.done = 1'b1;
                        state_next    = ST_IDLE;
                    end else begin
                        pos_next   = pos_reg + 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        pos_reg    <= pos_next;
        m_data_reg <= m_data_next;
    end

`ifndef ASSERT_OFF
    a_run_is_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (cmd_reg.kind == KIND_PAYLOAD))
        else $error("buffer read outside a payload run");
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (pos_reg <= IDX_W'(BUFFER_BYTES - 1)))
        else $error("payload position beyond buffer");
`endif

endmodule

>>> sv/prefixed_message_framer.sv
// ----------------------------------------------------------------------------
// prefixed_message_framer
// Frames prefixed messages from a byte stream and tracks link/send timing.
// ----------------------------------------------------------------------------
// A tick gives one status result and a failed prefix check one failure
// result. A verified message gives BUFFER_BYTES minus the prefix length
// (capped at PREFIX_MAX) payload results, each one read from the buffer RAM
// and then held in the output register. The buffer RAM holds two message
// banks, so bytes of the next message are taken while a run is still going
// out; the input stalls when the command queue is full or when both banks
// wait on payload runs.
module prefixed_message_framer
    import pmf_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
    parameter int CMD_DEPTH    = CMD_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data
);

    localparam int AW        = $clog2(BUFFER_BYTES) + 1;
    localparam int RAM_DEPTH = 2 * (1 << $clog2(BUFFER_BYTES));

    cfg_t      cfg_reg;
    logic      push;
    cmd_t      push_cmd;
    logic      fifo_full;
    logic      pop;
    cmd_t      pop_cmd;
    logic      fifo_empty;
    run_done_t run_done;
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [7:0]    ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [7:0]    ram_rd_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.separator_byte      <= 8'd10;
            cfg_reg.prefix_bytes        <= '0;
            cfg_reg.prefix_length       <= '0;
            cfg_reg.rx_timeout_ticks    <= 32'd1000;
            cfg_reg.send_interval_ticks <= 32'd1000;
            cfg_reg.send_enabled        <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SEPARATOR:     cfg_reg.separator_byte      <= cfg_wdata[7:0];
                REG_PREFIX:        cfg_reg.prefix_bytes        <= cfg_wdata;
                REG_PREFIX_LEN:    cfg_reg.prefix_length       <= cfg_wdata[3:0];
                REG_RX_TIMEOUT:    cfg_reg.rx_timeout_ticks    <= cfg_wdata[31:0];
                REG_SEND_INTERVAL: cfg_reg.send_interval_ticks <= cfg_wdata[31:0];
                REG_SEND_EN:       cfg_reg.send_enabled        <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    pmf_front #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .push        (push),
        .push_cmd    (push_cmd),
        .fifo_full   (fifo_full),
        .run_done    (run_done),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data)
    );

    pmf_cmd_fifo #(
        .DEPTH(CMD_DEPTH)
    ) u_cmd_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (fifo_full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (fifo_empty)
    );

    pmf_ram #(
        .WIDTH(8),
        .DEPTH(RAM_DEPTH)
    ) u_buffer (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    pmf_back #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .empty       (fifo_empty),
        .pop         (pop),
        .pop_cmd     (pop_cmd),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .run_done    (run_done),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule
